### rtl/core/pcaq_pkg.sv
// Package for the Q15 PCA projection unit: sizes, codes, the sequencer state type,
// the sequencer-to-datapath control struct and small helper functions.
// Depends on nothing; every other file of the unit imports it.
package pcaq_pkg;

  localparam int MAX_FEATURES   = 32;
  localparam int MAX_COMPONENTS = 8;

  localparam int COL_W      = $clog2(MAX_FEATURES);
  localparam int ROW_W      = $clog2(MAX_COMPONENTS);
  localparam int FCNT_W     = 6;
  localparam int CCNT_W     = 4;
  localparam int VAL_W      = 16;
  localparam int PROD_W     = 2 * VAL_W;
  localparam int ACC_W      = 40;
  localparam int SHIFT      = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [1:0] OP_LOAD_MEAN = 2'd0;
  localparam logic [1:0] OP_LOAD_COEF = 2'd1;
  localparam logic [1:0] OP_SAMPLE    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPONENT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_MEAN        = 2'd2;

  localparam logic signed [VAL_W-1:0] SAT_MAX = 16'sh7FFF;
  localparam logic signed [VAL_W-1:0] SAT_MIN = 16'sh8000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CENTER,
    ST_MUL,
    ST_ACC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic             center_en;
    logic             mul_en;
    logic             acc_en;
    logic             emit_en;
    logic             clr;
    logic             last;
    logic [ROW_W-1:0] idx;
  } ctl_t;

  // Feature count clamped to 1..MAX_FEATURES.
  function automatic logic [FCNT_W-1:0] eff_features(input logic [FCNT_W-1:0] n);
    logic [FCNT_W-1:0] r;
    r = n;
    if (n == '0) r = FCNT_W'(1);
    else if (n > FCNT_W'(MAX_FEATURES)) r = FCNT_W'(MAX_FEATURES);
    return r;
  endfunction

  // Component count clamped to 1..MAX_COMPONENTS.
  function automatic logic [CCNT_W-1:0] eff_components(input logic [CCNT_W-1:0] n);
    logic [CCNT_W-1:0] r;
    r = n;
    if (n == '0) r = CCNT_W'(1);
    else if (n > CCNT_W'(MAX_COMPONENTS)) r = CCNT_W'(MAX_COMPONENTS);
    return r;
  endfunction

  // Arithmetic shift right by SHIFT, then saturate to a signed 16-bit word.
  function automatic logic signed [VAL_W-1:0] scale_sat(input logic [ACC_W-1:0] acc);
    logic [ACC_W-SHIFT-VAL_W:0] hi;
    logic signed [VAL_W-1:0]    r;
    hi = acc[ACC_W-1:SHIFT+VAL_W-1];
    if ((&hi) || !(|hi)) r = acc[SHIFT+VAL_W-1:SHIFT];
    else if (acc[ACC_W-1]) r = SAT_MIN;
    else r = SAT_MAX;
    return r;
  endfunction

endpackage

### rtl/core/pca_projection_q15_unit.sv
// Q15 PCA projection unit: loads complete at the accept edge and never raise busy.
// A sample item holds busy through a centering step and then a multiply step and an
// accumulate step per active component (C of them) on the shared MAC.
// A sample that closes the vector adds a result step per component; results follow on
// C consecutive strobes. Reset clears the sequencer, accumulators and result strobe,
// sets the configuration registers to their defaults; the stores are not cleared.
module pca_projection_q15_unit import pcaq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              in_operation,
  input  logic [ROW_W-1:0]        in_row,
  input  logic [COL_W-1:0]        in_column,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  output logic [ROW_W-1:0]        out_component_index,
  output logic signed [VAL_W-1:0] out_projection,
  output logic                    out_last,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  // Configuration registers, to be written only while the unit is idle; not enforced.
  logic [FCNT_W-1:0] feature_count_r;
  logic [CCNT_W-1:0] component_count_r;
  logic              use_mean_r;

  // Column and value of the sample in flight.
  logic [COL_W-1:0]        col_r;
  logic signed [VAL_W-1:0] val_r;

  logic [FCNT_W-1:0]       n_feat;
  logic [CCNT_W-1:0]       n_comp;
  logic                    accept;
  logic                    sample_go;
  logic                    closes;
  logic                    mean_we;
  logic                    coef_we;
  ctl_t                    ctl;
  logic [ROW_W-1:0]        coef_row;
  logic signed [VAL_W-1:0] mean_q;
  logic signed [VAL_W-1:0] coef_q;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feature_count_r   <= FCNT_W'(MAX_FEATURES);
      component_count_r <= CCNT_W'(MAX_COMPONENTS);
      use_mean_r        <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FEATURE_COUNT:   feature_count_r   <= cfg_wdata[FCNT_W-1:0];
        CFG_COMPONENT_COUNT: component_count_r <= cfg_wdata[CCNT_W-1:0];
        CFG_USE_MEAN:        use_mean_r        <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign n_feat = eff_features(feature_count_r);
  assign n_comp = eff_components(component_count_r);

  // An item is taken whenever start meets an idle unit. Loads complete at that
  // edge; a sample whose column lies beyond the vector, and operation code 3,
  // are dropped without effect.
  assign accept    = start && !busy;
  assign mean_we   = accept && (in_operation == OP_LOAD_MEAN);
  assign coef_we   = accept && (in_operation == OP_LOAD_COEF);
  assign sample_go = accept && (in_operation == OP_SAMPLE) &&
                     (FCNT_W'(in_column) < n_feat);
  // The sample of the last column closes the vector, whatever the order before it.
  assign closes    = (FCNT_W'(in_column) == n_feat - FCNT_W'(1));

  always_ff @(posedge clk) begin
    if (sample_go) begin
      col_r <= in_column;
      val_r <= in_value;
    end
  end

  // The mean word is read at the accept edge and is ready in the centering cycle.
  pcaq_store u_store (
    .clk         (clk),
    .mean_we     (mean_we),
    .coef_we     (coef_we),
    .wr_row      (in_row),
    .wr_col      (in_column),
    .wr_data     (in_value),
    .mean_re     (!busy),
    .mean_rd_col (in_column),
    .coef_rd_row (coef_row),
    .coef_rd_col (col_r),
    .mean_q      (mean_q),
    .coef_q      (coef_q)
  );

  pcaq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .sample_go  (sample_go),
    .closes     (closes),
    .comp_count (n_comp),
    .busy       (busy),
    .ctl        (ctl),
    .coef_row   (coef_row)
  );

  pcaq_mac u_mac (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctl                 (ctl),
    .use_mean            (use_mean_r),
    .sample              (val_r),
    .mean_q              (mean_q),
    .coef_q              (coef_q),
    .out_valid           (out_valid),
    .out_component_index (out_component_index),
    .out_projection      (out_projection),
    .out_last            (out_last)
  );

endmodule

### rtl/core/pcaq_store.sv
// Mean and coefficient memories of the PCA projection unit, one write and one
// registered read port each. Depends on pcaq_pkg.
module pcaq_store import pcaq_pkg::*; (
  input  logic                    clk,
  input  logic                    mean_we,
  input  logic                    coef_we,
  input  logic [ROW_W-1:0]        wr_row,
  input  logic [COL_W-1:0]        wr_col,
  input  logic signed [VAL_W-1:0] wr_data,
  input  logic                    mean_re,
  input  logic [COL_W-1:0]        mean_rd_col,
  input  logic [ROW_W-1:0]        coef_rd_row,
  input  logic [COL_W-1:0]        coef_rd_col,
  output logic signed [VAL_W-1:0] mean_q,
  output logic signed [VAL_W-1:0] coef_q
);

  logic [VAL_W-1:0] mean_mem [MAX_FEATURES];
  logic [VAL_W-1:0] coef_mem [MAX_COMPONENTS*MAX_FEATURES];

  always_ff @(posedge clk) begin
    if (mean_we) begin
      mean_mem[wr_col] <= wr_data;
    end
    if (mean_re) begin
      mean_q <= mean_mem[mean_rd_col];
    end
  end

  // Row-major layout: the entry of a row and column sits at {row, column}.
  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[{wr_row, wr_col}] <= wr_data;
    end
    coef_q <= coef_mem[{coef_rd_row, coef_rd_col}];
  end

endmodule

### rtl/core/pcaq_mac.sv
// Shared multiply-accumulate datapath: centering, one 16x16 multiplier, the
// accumulator bank and the scaled, saturated result register. Depends on pcaq_pkg.
module pcaq_mac import pcaq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ctl_t                    ctl,
  input  logic                    use_mean,
  input  logic signed [VAL_W-1:0] sample,
  input  logic signed [VAL_W-1:0] mean_q,
  input  logic signed [VAL_W-1:0] coef_q,
  output logic                    out_valid,
  output logic [ROW_W-1:0]        out_component_index,
  output logic signed [VAL_W-1:0] out_projection,
  output logic                    out_last
);

  logic signed [VAL_W-1:0]  centered_r;
  logic signed [PROD_W-1:0] product_r;
  logic [ACC_W-1:0]         acc_r [MAX_COMPONENTS];
  logic                     valid_r;
  logic [ROW_W-1:0]         index_r;
  logic signed [VAL_W-1:0]  proj_r;
  logic                     last_r;

  // The centered value wraps within 16 bits.
  always_ff @(posedge clk) begin
    if (ctl.center_en) begin
      centered_r <= use_mean ? VAL_W'(sample - mean_q) : sample;
    end
    if (ctl.mul_en) begin
      product_r <= centered_r * coef_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      for (int i = 0; i < MAX_COMPONENTS; i++) begin
        acc_r[i] <= '0;
      end
    end else if (ctl.acc_en) begin
      acc_r[ctl.idx] <= acc_r[ctl.idx] + {{(ACC_W-PROD_W){product_r[PROD_W-1]}}, product_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl.emit_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_en) begin
      index_r <= ctl.idx;
      proj_r  <= scale_sat(acc_r[ctl.idx]);
      last_r  <= ctl.last;
    end
  end

  assign out_valid           = valid_r;
  assign out_component_index = index_r;
  assign out_projection      = proj_r;
  assign out_last            = last_r;

endmodule

### rtl/core/pcaq_ctrl.sv
// Sequencer of the PCA projection unit: walks the components of one sample
// through the shared multiply-accumulate and, when the sample closes the vector,
// through the result phase. Depends on pcaq_pkg.
module pcaq_ctrl import pcaq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              sample_go,
  input  logic              closes,
  input  logic [CCNT_W-1:0] comp_count,
  output logic              busy,
  output ctl_t              ctl,
  output logic [ROW_W-1:0]  coef_row
);

  state_t           state_r, state_nxt;
  logic [ROW_W-1:0] k_r, k_nxt;
  logic             closes_r, closes_nxt;
  logic             k_final;

  assign k_final = (CCNT_W'(k_r) == comp_count - CCNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      k_r      <= '0;
      closes_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      k_r      <= k_nxt;
      closes_r <= closes_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    closes_nxt = closes_r;
    ctl        = '0;
    ctl.idx    = k_r;
    ctl.last   = k_final;
    coef_row   = k_r;
    case (state_r)
      ST_IDLE: begin
        k_nxt = '0;
        if (sample_go) begin
          closes_nxt = closes;
          state_nxt  = ST_CENTER;
        end
      end
      ST_CENTER: begin
        ctl.center_en = 1'b1;
        state_nxt     = ST_MUL;
      end
      ST_MUL: begin
        ctl.mul_en = 1'b1;
        state_nxt  = ST_ACC;
      end
      ST_ACC: begin
        // Prefetch the next component's coefficient while this one accumulates.
        ctl.acc_en = 1'b1;
        coef_row   = k_r + ROW_W'(1);
        if (k_final) begin
          k_nxt     = '0;
          state_nxt = closes_r ? ST_EMIT : ST_IDLE;
        end else begin
          k_nxt     = k_r + ROW_W'(1);
          state_nxt = ST_MUL;
        end
      end
      ST_EMIT: begin
        ctl.emit_en = 1'b1;
        if (k_final) begin
          ctl.clr   = 1'b1;
          k_nxt     = '0;
          state_nxt = ST_IDLE;
        end else begin
          k_nxt = k_r + ROW_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

### rtl/core/pcaq_checker.sv
// Port-level checker for the Q15 PCA projection unit, bound to the top level.
// Depends on pcaq_pkg and pca_projection_q15_unit.
module pcaq_checker import pcaq_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    start,
  input logic                    busy,
  input logic [1:0]              in_operation,
  input logic                    out_valid,
  input logic [ROW_W-1:0]        out_component_index,
  input logic                    out_last
);

  // Results of one vector come on consecutive strobes.
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("result burst broken before its last item");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=>
      out_component_index == ROW_W'($past(out_component_index) + ROW_W'(1)))
    else $error("component index did not advance by one");

  a_index_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_component_index != '0 |-> $past(out_valid))
    else $error("burst started at a nonzero component");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_operation != OP_SAMPLE |=> !busy)
    else $error("load item made the unit busy");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid)
    else $error("unit not idle after reset");

endmodule

bind pca_projection_q15_unit pcaq_checker u_pcaq_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .start               (start),
  .busy                (busy),
  .in_operation        (in_operation),
  .out_valid           (out_valid),
  .out_component_index (out_component_index),
  .out_last            (out_last)
);

### test/tb_pca_projection_q15_unit.sv
// Self-checking testbench for pca_projection_q15_unit: directed and random load and sample
// items, with every result checked against a predictor written inside this bench.
// Depends on pcaq_pkg and the unit's RTL only.
module tb_pca_projection_q15_unit;
  import pcaq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Register index 3 has no register behind it; a write there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;
  // Operation code 3 is not defined; the unit must drop such an item.
  localparam logic [1:0]           OP_RESERVED = 2'd3;

  // The first result follows the centering, multiply and accumulate steps, then the rest
  // come, so this covers a sample in flight plus a full burst with room to spare.
  localparam int SETTLE_CYCLES = 4 * MAX_COMPONENTS + 8;
  localparam int RANDOM_ITEMS  = 470;
  localparam int PHASE_ITEMS   = 60;
  localparam int CYCLE_LIMIT   = 500000;

  typedef enum bit {STEP_ITEM, STEP_REG} step_kind_t;

  // One row of the directed table. For a register row, op holds the register index and
  // the low bits of value hold the write data. When typed is set, proj0 is the
  // projection expected for component 0, worked out by hand.
  typedef struct packed {
    step_kind_t       kind;
    logic [1:0]       op;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] value;
    logic             typed;
    logic [VAL_W-1:0] proj0;
  } dir_step_t;

  // One expected result of the unit.
  typedef struct packed {
    logic [ROW_W-1:0] idx;
    logic [VAL_W-1:0] proj;
    logic             last;
  } proj_t;

  // Clock, reset and every input of the unit start at known values.
  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [1:0]              in_operation = '0;
  logic [ROW_W-1:0]        in_row = '0;
  logic [COL_W-1:0]        in_column = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_valid;
  logic [ROW_W-1:0]        out_component_index;
  logic signed [VAL_W-1:0] out_projection;
  logic                    out_last;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

  // Predictor state: its own copy of the registers, both stores with a written flag per
  // entry, and the component accumulators.
  logic [FCNT_W-1:0] fc_reg = FCNT_W'(32);
  logic [CCNT_W-1:0] cc_reg = CCNT_W'(8);
  logic              um_reg = 1'b1;
  logic [VAL_W-1:0]  mean_mem [MAX_FEATURES];
  logic [VAL_W-1:0]  coef_mem [MAX_COMPONENTS][MAX_FEATURES];
  bit                mean_ok  [MAX_FEATURES];
  bit                coef_ok  [MAX_COMPONENTS][MAX_FEATURES];
  logic [ACC_W-1:0]  acc_model [MAX_COMPONENTS];

  proj_t     pending_proj[$];
  dir_step_t directed_steps[$];

  int fail_count  = 0;
  int items_sent  = 0;
  int proj_seen   = 0;
  int reg_writes  = 0;
  int cycle_count = 0;
  int idle_pct    = 38;

  pca_projection_q15_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_row              (in_row),
    .in_column           (in_column),
    .in_value            (in_value),
    .out_valid           (out_valid),
    .out_component_index (out_component_index),
    .out_projection      (out_projection),
    .out_last            (out_last),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, pending_proj.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // The register counts as the unit sees them, clamped to the sizes it supports.
  function automatic int active_features();
    if (fc_reg == '0) return 1;
    if (fc_reg > FCNT_W'(MAX_FEATURES)) return MAX_FEATURES;
    return int'(fc_reg);
  endfunction

  function automatic int active_components();
    if (cc_reg == '0) return 1;
    if (cc_reg > CCNT_W'(MAX_COMPONENTS)) return MAX_COMPONENTS;
    return int'(cc_reg);
  endfunction

  // Random data, with the Q15 extremes, zero and all-ones drawn more often than chance.
  function automatic logic [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] v;
    case ($urandom_range(11))
      0:       v = 16'h8000;
      1:       v = 16'h7FFF;
      2:       v = 16'h0000;
      3:       v = 16'hFFFF;
      default: v = VAL_W'($urandom);
    endcase
    return v;
  endfunction

  function automatic dir_step_t mk_item(input logic [1:0] op, input int row, input int col,
                                        input logic [VAL_W-1:0] val);
    dir_step_t s;
    s = '{kind: STEP_ITEM, op: op, row: ROW_W'(row), col: COL_W'(col), value: val,
          typed: 1'b0, proj0: '0};
    return s;
  endfunction

  function automatic dir_step_t mk_check(input logic [1:0] op, input int col,
                                         input logic [VAL_W-1:0] val,
                                         input logic [VAL_W-1:0] proj0);
    dir_step_t s;
    s = mk_item(op, 0, col, val);
    s.typed = 1'b1;
    s.proj0 = proj0;
    return s;
  endfunction

  function automatic dir_step_t mk_reg(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
    dir_step_t s;
    s = mk_item(idx, 0, 0, VAL_W'(data));
    s.kind = STEP_REG;
    return s;
  endfunction

  // Works out what one accepted item does: loads fill the stores, a sample in range
  // centers itself, feeds every active component, and the last column of the vector
  // queues one projection per active component before the accumulators are cleared.
  task automatic predict_projection(input logic [1:0] op, input logic [ROW_W-1:0] row,
                                    input logic [COL_W-1:0] col, input logic [VAL_W-1:0] val,
                                    input logic typed, input logic [VAL_W-1:0] proj0);
    int                      nf;
    int                      nc;
    logic [VAL_W-1:0]        centered;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0] scaled;
    proj_t                   r;
    nf = active_features();
    nc = active_components();
    case (op)
      OP_LOAD_MEAN: begin
        mean_mem[col] = val;
        mean_ok[col]  = 1'b1;
      end
      OP_LOAD_COEF: begin
        coef_mem[row][col] = val;
        coef_ok[row][col]  = 1'b1;
      end
      OP_SAMPLE: begin
        if (int'(col) < nf) begin
          // The difference is kept to 16 bits, so it wraps rather than grows.
          centered = um_reg ? val - mean_mem[col] : val;
          for (int k = 0; k < nc; k++) begin
            prod = $signed(centered) * $signed(coef_mem[k][col]);
            acc_model[k] = acc_model[k] + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
          end
          if (int'(col) == nf - 1) begin
            for (int k = 0; k < nc; k++) begin
              scaled = $signed(acc_model[k]) >>> SHIFT;
              if (scaled > 40'sd32767) r.proj = SAT_MAX;
              else if (scaled < -40'sd32768) r.proj = SAT_MIN;
              else r.proj = scaled[VAL_W-1:0];
              if (k == 0 && typed) r.proj = proj0;
              r.idx  = ROW_W'(k);
              r.last = (k == nc - 1);
              pending_proj.push_back(r);
            end
            for (int k = 0; k < MAX_COMPONENTS; k++) acc_model[k] = '0;
          end
        end
      end
      default: ;
    endcase
  endtask

  // Presents one item from a falling edge and holds it until the unit takes it. Start is
  // left high after the accept edge; the next call either replaces the item at the next
  // falling edge or idles, and anything else first calls lower_start.
  task automatic issue_item(input logic [1:0] op, input logic [ROW_W-1:0] row,
                            input logic [COL_W-1:0] col, input logic [VAL_W-1:0] val,
                            input logic typed, input logic [VAL_W-1:0] proj0);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start        <= 1'b1;
    in_operation <= op;
    in_row       <= row;
    in_column    <= col;
    in_value     <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_projection(op, row, col, val, typed, proj0);
    items_sent++;
  endtask

  task automatic lower_start();
    @(negedge clk);
    start <= 1'b0;
  endtask

  // Stops sending until every expected result is in and the unit is no longer busy. With
  // settle set it also sits out a sample that makes no result but may still be running,
  // which is what a register write needs.
  task automatic wait_drained(input bit settle);
    lower_start();
    while (pending_proj.size() != 0 || busy) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FEATURE_COUNT:   fc_reg = data;
      CFG_COMPONENT_COUNT: cc_reg = data[CCNT_W-1:0];
      CFG_USE_MEAN:        um_reg = data[0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // The stores come out of reset undefined, so before a sample reads a column the mean and
  // every active coefficient of that column are loaded with random data if still unwritten.
  // The mean is filled even when centering is off, in case the unit reads it anyway.
  task automatic ensure_written(input int col);
    if (col >= active_features()) return;
    if (!mean_ok[col])
      issue_item(OP_LOAD_MEAN, ROW_W'($urandom), COL_W'(col), pick_value(), 1'b0, '0);
    for (int k = 0; k < active_components(); k++)
      if (!coef_ok[k][col])
        issue_item(OP_LOAD_COEF, ROW_W'(k), COL_W'(col), pick_value(), 1'b0, '0);
  endtask

  // Result checker: the receiver cannot stall, so every strobe is compared with the
  // oldest expectation right at the edge that ends its cycle.
  always @(posedge clk) begin : check_results
    proj_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_proj.size() == 0) begin
        fail_count++;
        $error("result with no expectation: component_index %0d projection %0d last %0b",
               out_component_index, out_projection, out_last);
      end else begin
        want = pending_proj.pop_front();
        proj_seen++;
        if (out_component_index !== want.idx) begin
          fail_count++;
          $error("component_index: expected %0d, got %0d", want.idx, out_component_index);
        end
        if (out_projection !== want.proj) begin
          fail_count++;
          $error("projection: expected %0d, got %0d", $signed(want.proj), out_projection);
        end
        if (out_last !== want.last) begin
          fail_count++;
          $error("last: expected %0b, got %0b", want.last, out_last);
        end
      end
    end
  end

  initial begin
    dir_step_t        s;
    int               nf;
    int               col;
    int               dir_items;
    int               phase;
    int               phase_end;
    logic [FCNT_W-1:0] fc;
    logic [CCNT_W-1:0] cc;
    logic              um;

    for (int k = 0; k < MAX_COMPONENTS; k++) acc_model[k] = '0;

    // Synchronous reset, released on a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table. Single feature, single component (both registers written as zero,
    // which clamps to one), centering on. A mean of -32768 turns the sample 32767 into
    // -1 and the sample 0 into -32768, both through 16-bit wrap; the second squares to
    // 2^30 and saturates high. The mean load carries a row that must be ignored.
    directed_steps.push_back(mk_reg(CFG_FEATURE_COUNT, 6'd0));
    directed_steps.push_back(mk_reg(CFG_COMPONENT_COUNT, 6'd0));
    directed_steps.push_back(mk_reg(CFG_USE_MEAN, 6'd1));
    directed_steps.push_back(mk_item(OP_LOAD_MEAN, 5, 0, 16'h8000));
    directed_steps.push_back(mk_item(OP_LOAD_COEF, 0, 0, 16'h8000));
    directed_steps.push_back(mk_check(OP_SAMPLE, 0, 16'h7FFF, 16'h0001));
    // An undefined operation and a sample past the vector both make nothing.
    directed_steps.push_back(mk_item(OP_RESERVED, 7, 31, 16'hFFFF));
    directed_steps.push_back(mk_item(OP_SAMPLE, 0, 1, 16'h1234));
    directed_steps.push_back(mk_check(OP_SAMPLE, 0, 16'h0000, 16'h7FFF));
    // Centering off: the most negative sample against the largest coefficient.
    directed_steps.push_back(mk_reg(CFG_USE_MEAN, 6'd0));
    directed_steps.push_back(mk_item(OP_LOAD_COEF, 0, 0, 16'h7FFF));
    directed_steps.push_back(mk_check(OP_SAMPLE, 0, 16'h8000, 16'h8001));
    // Both counts above range clamp to the maximum. Only the last column is sent, so the
    // vector closes with no earlier column, and all eight components report.
    directed_steps.push_back(mk_reg(CFG_FEATURE_COUNT, 6'd40));
    directed_steps.push_back(mk_reg(CFG_COMPONENT_COUNT, 6'd15));
    directed_steps.push_back(mk_reg(CFG_USE_MEAN, 6'd1));
    directed_steps.push_back(mk_item(OP_LOAD_MEAN, 0, 31, 16'h0000));
    directed_steps.push_back(mk_item(OP_LOAD_COEF, 0, 31, 16'h7FFF));
    directed_steps.push_back(mk_item(OP_LOAD_COEF, 1, 31, 16'h8000));
    directed_steps.push_back(mk_item(OP_LOAD_COEF, 2, 31, 16'h0001));
    directed_steps.push_back(mk_item(OP_LOAD_COEF, 3, 31, 16'hFFFF));
    directed_steps.push_back(mk_item(OP_LOAD_COEF, 4, 31, 16'h4000));
    directed_steps.push_back(mk_item(OP_LOAD_COEF, 5, 31, 16'hC000));
    directed_steps.push_back(mk_item(OP_LOAD_COEF, 6, 31, 16'h0000));
    directed_steps.push_back(mk_item(OP_LOAD_COEF, 7, 31, 16'h8000));
    directed_steps.push_back(mk_check(OP_SAMPLE, 31, 16'h8000, 16'h8001));
    // Two features, one component, no centering. Column 0 arrives twice before the last
    // column; three large negative products push the sum below range and it saturates low.
    directed_steps.push_back(mk_reg(CFG_FEATURE_COUNT, 6'd2));
    directed_steps.push_back(mk_reg(CFG_COMPONENT_COUNT, 6'd1));
    directed_steps.push_back(mk_reg(CFG_USE_MEAN, 6'd0));
    directed_steps.push_back(mk_item(OP_LOAD_COEF, 0, 1, 16'h7FFF));
    directed_steps.push_back(mk_item(OP_LOAD_MEAN, 7, 1, 16'h5A5A));
    directed_steps.push_back(mk_item(OP_SAMPLE, 0, 0, 16'h8000));
    directed_steps.push_back(mk_item(OP_SAMPLE, 0, 0, 16'h8000));
    directed_steps.push_back(mk_check(OP_SAMPLE, 1, 16'h8000, 16'h8000));

    foreach (directed_steps[i]) begin
      s = directed_steps[i];
      if (s.kind == STEP_REG) begin
        wait_drained(1'b1);
        write_reg(s.op, s.value[CFG_DATA_W-1:0]);
      end else begin
        issue_item(s.op, s.row, s.col, s.value, s.typed, s.proj0);
      end
    end
    dir_items = items_sent;

    // Random part, in phases. Each phase drains the unit, writes all three registers, then
    // mostly sends whole vectors in column order with random data. The rest is noise:
    // undefined operations, stray or out-of-order samples, and loads anywhere in the stores.
    phase = 0;
    while (items_sent - dir_items < RANDOM_ITEMS) begin
      wait_drained(1'b1);
      case (phase)
        0: begin fc = 6'd1;  cc = 4'd8;  um = 1'b1; end
        1: begin fc = 6'd32; cc = 4'd15; um = 1'b0; end
        2: begin fc = 6'd0;  cc = 4'd1;  um = 1'b1; end
        5: begin fc = 6'd63; cc = 4'd2;  um = 1'b1; end
        default: begin
          fc = ($urandom_range(9) == 0) ? FCNT_W'($urandom_range(63, 33))
                                        : FCNT_W'($urandom_range(6, 1));
          cc = CCNT_W'($urandom_range(15));
          um = 1'($urandom);
        end
      endcase
      // Unused upper data bits are random; the unit must ignore them.
      write_reg(CFG_FEATURE_COUNT, fc);
      write_reg(CFG_COMPONENT_COUNT, {2'($urandom), cc});
      write_reg(CFG_USE_MEAN, {5'($urandom), um});
      if (phase == 3) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
      // The long full-width phase runs with the sender never idling.
      idle_pct = (phase == 1) ? 0 : 38;

      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        nf = active_features();
        if ($urandom_range(99) < 80) begin
          for (int c = 0; c < nf; c++) begin
            // Now and then a coefficient or mean is replaced between samples of a vector.
            if ($urandom_range(9) == 0)
              issue_item($urandom_range(1) ? OP_LOAD_COEF : OP_LOAD_MEAN,
                         ROW_W'($urandom_range(active_components() - 1)), COL_W'(c),
                         pick_value(), 1'b0, '0);
            ensure_written(c);
            issue_item(OP_SAMPLE, ROW_W'($urandom), COL_W'(c), pick_value(), 1'b0, '0);
          end
          // The sender sometimes holds off until every result has come back.
          if ($urandom_range(5) == 0) wait_drained(1'b0);
        end else begin
          case ($urandom_range(3))
            0: issue_item(OP_RESERVED, ROW_W'($urandom), COL_W'($urandom), pick_value(),
                          1'b0, '0);
            1: begin
              // Any column: past the vector it is dropped, inside it is out of order.
              col = $urandom_range(MAX_FEATURES - 1);
              ensure_written(col);
              issue_item(OP_SAMPLE, ROW_W'($urandom), COL_W'(col), pick_value(), 1'b0, '0);
            end
            2: issue_item(OP_LOAD_MEAN, ROW_W'($urandom), COL_W'($urandom), pick_value(),
                          1'b0, '0);
            default: issue_item(OP_LOAD_COEF, ROW_W'($urandom), COL_W'($urandom),
                                pick_value(), 1'b0, '0);
          endcase
        end
      end
      phase++;
    end

    // Let the last results come home and give the unit time to show any stray strobe.
    wait_drained(1'b1);
    if (pending_proj.size() != 0) begin
      fail_count++;
      $error("%0d expected results never arrived", pending_proj.size());
    end

    $display("Run covered %0d items (%0d directed) over %0d phases and %0d register writes,",
             items_sent, dir_items, phase, reg_writes);
    $display("with %0d projections compared and %0d mismatches.", proj_seen, fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/pcaq_pkg.sv
rtl/core/pcaq_store.sv
rtl/core/pcaq_mac.sv
rtl/core/pcaq_ctrl.sv
rtl/core/pca_projection_q15_unit.sv
rtl/core/pcaq_checker.sv
test/tb_pca_projection_q15_unit.sv
